// ===== design/rsa_pkg.sv =====
// Shared constants and types for the region slot allocator.
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int ADDR_BITS = 16;
  localparam int AMT_W     = 16;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 4;
  localparam int OFF_W     = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [AMT_W-1:0] CAP_RESET = AMT_W'(4000);

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] bump;
    logic [ADDR_BITS-1:0] size;
    logic [ADDR_BITS-1:0] start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/rsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/region_slot_allocator_core.sv =====
// Region slot allocator: first-fit region placement, bump reserve and free.
//
//  channel | ports                           | payload (low bit first)
//  --------+---------------------------------+---------------------------------------
//  in      | in_tvalid / in_tready / in_tdata   | cmd[1:0] slot[5:2] amount[21:6]
//  out     | out_tvalid / out_tready / out_tdata| ok[0] slot_index[4:1] offset[20:5]
//  cfg     | cfg_wr_en / cfg_wr_data         | pool_capacity[15:0]
//
// Allocate reads the slot table one entry per cycle through a single RAM read
// port: a setup state (ST_AFIRST), a walk over up to 16 slots, then ST_RESP.
// Reserve passes through ST_RSV before ST_RESP; free and rejected items go straight to ST_RESP.
// Reset clears all slots at once through per-slot valid bits; no clearing pass.
// One item in flight; a finished item waits in the output register while the
// next one is accepted, and the handoff stalls only if that register is full.
`timescale 1ns / 1ps

module region_slot_allocator_core
  import rsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cmd, slot, amount
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // ok, slot_index, offset
  input  logic                  cfg_wr_en,
  input  logic [AMT_W-1:0]      cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AFIRST,
    ST_AWALK,
    ST_RSV,
    ST_RESP
  } state_t;

  state_t               state_r;
  logic [AMT_W-1:0]     cap_r;
  logic [SLOTS-1:0]     valid_r;
  logic                 rvalid_r;
  logic [IDX_W-1:0]     slot_r;
  logic [AMT_W-1:0]     amount_r;
  logic [ADDR_BITS:0]   cursor_r;
  entry_t               cur_r;
  logic [SLOT_W-1:0]    idx_r;
  logic                 res_ok_r;
  logic [IDX_W-1:0]     res_slot_r;
  logic [OFF_W-1:0]     res_off_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [CMD_W-1:0]     in_cmd;
  logic [IDX_W-1:0]     in_slot;
  logic [AMT_W-1:0]     in_amount;
  logic                 slot_ok;

  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  entry_t               ram_wdata;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               ent;

  logic [ADDR_BITS+1:0] fit_sum;
  logic                 no_room;
  logic                 is_last;
  logic                 place;
  logic [ADDR_BITS:0]   rsv_sum;
  logic [ADDR_BITS:0]   rsv_lim;
  logic                 rsv_fail;
  logic                 out_free;

  assign in_cmd    = in_tdata[1:0];
  assign in_slot   = in_tdata[5:2];
  assign in_amount = in_tdata[21:6];
  assign slot_ok   = (int'(in_slot) < SLOTS);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign ent = rvalid_r ? entry_t'(ram_rdata) : '0;

  // walk step for slot idx_r; ent holds slot idx_r+1
  assign fit_sum = (ADDR_BITS+2)'(cursor_r) + (ADDR_BITS+2)'(amount_r);
  assign no_room = fit_sum >= (ADDR_BITS+2)'(cap_r);
  assign is_last = (int'(idx_r) == SLOTS - 1);
  assign place   = (cur_r.size == '0) &&
                   (is_last || ent.size == '0 || fit_sum <= (ADDR_BITS+2)'(ent.start));

  assign rsv_sum  = (ADDR_BITS+1)'(ent.bump) + (ADDR_BITS+1)'(amount_r);
  assign rsv_lim  = (ADDR_BITS+1)'(ent.start) + (ADDR_BITS+1)'(ent.size);
  assign rsv_fail = rsv_sum >= rsv_lim;

  always_comb begin
    case (state_r)
      ST_IDLE:   ram_raddr = (in_cmd == CMD_ALLOC) ? '0 : SLOT_W'(in_slot);
      ST_AFIRST: ram_raddr = SLOT_W'(1);
      ST_AWALK:  ram_raddr = idx_r + SLOT_W'(2);
      default:   ram_raddr = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    if (state_r == ST_AWALK && !no_room && place) begin
      ram_we          = 1'b1;
      ram_wdata.start = ADDR_BITS'(cursor_r);
      ram_wdata.size  = ADDR_BITS'(amount_r);
      ram_wdata.bump  = ADDR_BITS'(cursor_r);
    end else if (state_r == ST_RSV && !rsv_fail) begin
      ram_we         = 1'b1;
      ram_waddr      = SLOT_W'(slot_r);
      ram_wdata      = ent;
      ram_wdata.bump = ADDR_BITS'(rsv_sum);
    end
  end

  rsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rvalid_r <= valid_r[ram_raddr];
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            slot_r     <= in_slot;
            amount_r   <= in_amount;
            res_ok_r   <= 1'b0;
            res_slot_r <= in_slot;
            res_off_r  <= '0;
            if (in_cmd == CMD_ALLOC) begin
              state_r <= ST_AFIRST;
            end else if (in_cmd == CMD_RESERVE && slot_ok) begin
              state_r <= ST_RSV;
            end else if (in_cmd == CMD_FREE && slot_ok) begin
              valid_r[SLOT_W'(in_slot)] <= 1'b0;
              res_ok_r <= 1'b1;
              state_r  <= ST_RESP;
            end else begin
              state_r <= ST_RESP;
            end
          end
        end
        ST_AFIRST: begin
          cur_r    <= ent;
          cursor_r <= '0;
          idx_r    <= '0;
          state_r  <= ST_AWALK;
        end
        ST_AWALK: begin
          if (no_room) begin
            res_ok_r   <= 1'b0;
            res_slot_r <= '0;
            res_off_r  <= '0;
            state_r    <= ST_RESP;
          end else if (place) begin
            res_ok_r   <= 1'b1;
            res_slot_r <= IDX_W'(idx_r);
            res_off_r  <= OFF_W'(cursor_r);
            state_r    <= ST_RESP;
          end else if (is_last) begin
            res_ok_r   <= 1'b0;
            res_slot_r <= '0;
            res_off_r  <= '0;
            state_r    <= ST_RESP;
          end else begin
            if (cur_r.size != '0) begin
              cursor_r <= (ADDR_BITS+1)'(cur_r.start) + (ADDR_BITS+1)'(cur_r.size);
            end
            cur_r <= ent;
            idx_r <= idx_r + SLOT_W'(1);
          end
        end
        ST_RSV: begin
          if (!rsv_fail) begin
            res_ok_r  <= 1'b1;
            res_off_r <= OFF_W'(ent.bump);
          end
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'b000, res_off_r, res_slot_r, res_ok_r};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
